// ----- design/des_pkg.sv -----
package des_pkg;

   localparam int unsigned ROUNDS = 16;

   typedef logic [5:0] six_type;
   typedef logic [3:0] nib_type;

   typedef logic [47:0] subkey_type;
   typedef subkey_type [ROUNDS-1:0] subkey_arr_type;

   localparam logic [7:0] IP_TAB [64] = '{
      8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,8'd10,8'd2, 8'd60,8'd52,8'd44,8'd36,8'd28,8'd20,8'd12,8'd4,
      8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,8'd14,8'd6, 8'd64,8'd56,8'd48,8'd40,8'd32,8'd24,8'd16,8'd8,
      8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1, 8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,
      8'd61,8'd53,8'd45,8'd37,8'd29,8'd21,8'd13,8'd5, 8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7};

   localparam logic [7:0] FP_TAB [64] = '{
      8'd40,8'd8,8'd48,8'd16,8'd56,8'd24,8'd64,8'd32, 8'd39,8'd7,8'd47,8'd15,8'd55,8'd23,8'd63,8'd31,
      8'd38,8'd6,8'd46,8'd14,8'd54,8'd22,8'd62,8'd30, 8'd37,8'd5,8'd45,8'd13,8'd53,8'd21,8'd61,8'd29,
      8'd36,8'd4,8'd44,8'd12,8'd52,8'd20,8'd60,8'd28, 8'd35,8'd3,8'd43,8'd11,8'd51,8'd19,8'd59,8'd27,
      8'd34,8'd2,8'd42,8'd10,8'd50,8'd18,8'd58,8'd26, 8'd33,8'd1,8'd41,8'd9,8'd49,8'd17,8'd57,8'd25};

   localparam logic [7:0] E_TAB [48] = '{
      8'd32,8'd1,8'd2,8'd3,8'd4,8'd5, 8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,
      8'd8,8'd9,8'd10,8'd11,8'd12,8'd13, 8'd12,8'd13,8'd14,8'd15,8'd16,8'd17,
      8'd16,8'd17,8'd18,8'd19,8'd20,8'd21, 8'd20,8'd21,8'd22,8'd23,8'd24,8'd25,
      8'd24,8'd25,8'd26,8'd27,8'd28,8'd29, 8'd28,8'd29,8'd30,8'd31,8'd32,8'd1};

   localparam logic [7:0] P_TAB [32] = '{
      8'd16,8'd7,8'd20,8'd21,8'd29,8'd12,8'd28,8'd17, 8'd1,8'd15,8'd23,8'd26,8'd5,8'd18,8'd31,8'd10,
      8'd2,8'd8,8'd24,8'd14,8'd32,8'd27,8'd3,8'd9, 8'd19,8'd13,8'd30,8'd6,8'd22,8'd11,8'd4,8'd25};

   localparam logic [7:0] PC1_TAB [56] = '{
      8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9, 8'd1,8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,
      8'd10,8'd2,8'd59,8'd51,8'd43,8'd35,8'd27, 8'd19,8'd11,8'd3,8'd60,8'd52,8'd44,8'd36,
      8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15, 8'd7,8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,
      8'd14,8'd6,8'd61,8'd53,8'd45,8'd37,8'd29, 8'd21,8'd13,8'd5,8'd28,8'd20,8'd12,8'd4};

   localparam logic [7:0] PC2_TAB [48] = '{
      8'd14,8'd17,8'd11,8'd24,8'd1,8'd5, 8'd3,8'd28,8'd15,8'd6,8'd21,8'd10,
      8'd23,8'd19,8'd12,8'd4,8'd26,8'd8, 8'd16,8'd7,8'd27,8'd20,8'd13,8'd2,
      8'd41,8'd52,8'd31,8'd37,8'd47,8'd55, 8'd30,8'd40,8'd51,8'd45,8'd33,8'd48,
      8'd44,8'd49,8'd39,8'd56,8'd34,8'd53, 8'd46,8'd42,8'd50,8'd36,8'd29,8'd32};

   localparam logic [1:0] ROT_TAB [16] = '{
      2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1};

   localparam logic [3:0] S_TAB [8][64] = '{
      '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
        4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
        4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
        4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
      '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
        4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
        4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
        4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
      '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
        4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
        4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
        4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
      '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
        4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
        4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
        4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
      '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
        4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
        4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
        4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
      '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
        4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
        4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
        4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
      '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
        4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
        4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
        4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
      '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
        4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
        4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
        4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

   // table positions count from 1 at the msb
   function automatic logic [63:0] perm64(input logic [63:0] src, input logic [7:0] tab [64]);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[63-i] = src[64 - int'(tab[i])];
      return r;
   endfunction

   function automatic logic [31:0] feistel(input logic [31:0] rh, input subkey_type sk);
      logic [47:0] x;
      logic [31:0] s;
      logic [31:0] p;
      six_type     six;
      for (int i = 0; i < 48; i++) x[47-i] = rh[32 - int'(E_TAB[i])];
      x = x ^ sk;
      for (int i = 0; i < 8; i++) begin
         six = x[47-6*i -: 6];
         s[31-4*i -: 4] = S_TAB[i][{six[5], six[0], six[4:1]}];
      end
      for (int i = 0; i < 32; i++) p[31-i] = s[32 - int'(P_TAB[i])];
      return p;
   endfunction

   function automatic subkey_arr_type make_subkeys(input logic [63:0] key);
      logic [55:0]    cd;
      logic [27:0]    c;
      logic [27:0]    d;
      subkey_arr_type sub;
      for (int i = 0; i < 56; i++) cd[55-i] = key[64 - int'(PC1_TAB[i])];
      c = cd[55:28];
      d = cd[27:0];
      for (int r = 0; r < ROUNDS; r++) begin
         if (ROT_TAB[r] == 2'd1) begin
            c = {c[26:0], c[27]};
            d = {d[26:0], d[27]};
         end else begin
            c = {c[25:0], c[27:26]};
            d = {d[25:0], d[27:26]};
         end
         cd = {c, d};
         for (int i = 0; i < 48; i++) sub[r][47-i] = cd[56 - int'(PC2_TAB[i])];
      end
      return sub;
   endfunction

endpackage

// ----- design/des_block_cipher_top.sv -----
// DES in ECB mode. One transaction per cycle is accepted unless the pipe is
// halted; the result reaches rsp_tvalid through 18 register stages (input
// permutation stage, sixteen round stages, output stage), each round being
// one pipeline stage. The whole pipe halts while
// rsp_tready is low and a result waits. Subkeys are derived from csr_wdata
// when it is written and held in registers; write the key only while idle.
module des_block_cipher_top
   import des_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [63:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // text_in
   input  logic        req_tuser,   // operation: 0 encrypt, 1 decrypt
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // text_out
);
   subkey_arr_type sub_ff;
   logic           adv;
   logic           vld [ROUNDS+1];
   logic           dec [ROUNDS+1];
   logic [63:0]    lr  [ROUNDS+1];
   logic           out_vld_ff;
   logic [63:0]    out_ff;

   always_ff @(posedge clock) begin
      if (reset) sub_ff <= make_subkeys(64'd0);
      else if (csr_we) sub_ff <= make_subkeys(csr_wdata);
   end

   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;

   logic        v0_ff;
   logic        d0_ff;
   logic [63:0] b0_ff;
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (adv) v0_ff <= req_tvalid;
      if (adv) begin
         d0_ff <= req_tuser;
         b0_ff <= perm64(req_tdata, IP_TAB);
      end
   end
   assign vld[0] = v0_ff;
   assign dec[0] = d0_ff;
   assign lr[0]  = b0_ff;

   for (genvar g = 0; g < ROUNDS; g++) begin : g_rnd
      des_round u_round (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .vld_i  (vld[g]),
         .dec_i  (dec[g]),
         .lr_i   (lr[g]),
         .key_enc(sub_ff[g]),
         .key_dec(sub_ff[ROUNDS-1-g]),
         .vld_o  (vld[g+1]),
         .dec_o  (dec[g+1]),
         .lr_o   (lr[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (adv) out_vld_ff <= vld[ROUNDS];
      if (adv) out_ff <= perm64({lr[ROUNDS][31:0], lr[ROUNDS][63:32]}, FP_TAB);
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;

`ifndef SYNTHESIS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready mismatch");
   a_first: assert property (@(posedge clock) disable iff (reset)
      adv && v0_ff |=> vld[1])
      else $error("valid lost in first round");
`endif
endmodule

// ----- design/des_round.sv -----
// one feistel round with its pipeline register and valid bit
module des_round
   import des_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        vld_i,
   input  logic        dec_i,
   input  logic [63:0] lr_i,
   input  subkey_type  key_enc,
   input  subkey_type  key_dec,
   output logic        vld_o,
   output logic        dec_o,
   output logic [63:0] lr_o
);
   logic        vld_ff;
   logic        dec_ff;
   logic [63:0] lr_ff;
   logic [63:0] lr_in;
   subkey_type  sk;

   assign sk    = dec_i ? key_dec : key_enc;
   assign lr_in = {lr_i[31:0], lr_i[63:32] ^ feistel(lr_i[31:0], sk)};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_i;
      end
      if (adv) begin
         dec_ff <= dec_i;
         lr_ff  <= lr_in;
      end
   end

   assign vld_o = vld_ff;
   assign dec_o = dec_ff;
   assign lr_o  = lr_ff;
endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
   import des_pkg::*;

   localparam int LATENCY = 18;
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1850;

   typedef struct packed {
      logic        decrypt;
      logic [63:0] block;
   } cipher_req_t;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [63:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;

   des_block_cipher_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   cipher_req_t     pending_blocks[$];
   logic [63:0]     expected_text[$];
   logic [47:0]     round_keys[16];
   int              errors = 0;
   int              idle_cycles = 0;
   int              send_wait = 0;
   int              recv_wait = 0;
   int              long_hold = 0;
   bit              timed_out = 0;
   bit              req_taken = 0;

   // bit n of the standard is word bit (width - n)
   function automatic logic [63:0] select_bits(input logic [63:0] src, input int width,
                                               input int n, input int pos[]);
      logic [63:0] r = '0;
      for (int i = 0; i < n; i++) r = {r[62:0], src[width - pos[i]]};
      return r;
   endfunction

   function automatic void schedule_keys(input logic [63:0] key);
      int pc1[] = '{57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
                    60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,
                    37,29,21,13,5,28,20,12,4};
      int pc2[] = '{14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
                    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,
                    29,32};
      int shifts[] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
      logic [55:0] cd;
      logic [27:0] c;
      logic [27:0] d;
      cd = 56'(select_bits(key, 64, 56, pc1));
      c = cd[55:28];
      d = cd[27:0];
      for (int r = 0; r < 16; r++) begin
         for (int s = 0; s < shifts[r]; s++) begin
            c = {c[26:0], c[27]};
            d = {d[26:0], d[27]};
         end
         round_keys[r] = 48'(select_bits({8'h0, c, d}, 56, 48, pc2));
      end
   endfunction

   function automatic logic [31:0] round_fn(input logic [31:0] rh, input logic [47:0] sk);
      int ex[] = '{32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
                   16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
      int pp[] = '{16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
                   2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
      int sb[8][64] = '{
         '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
           4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
         '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
           0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
         '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
           13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
         '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
           10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
         '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
           4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
         '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
           9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
         '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
           1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
         '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
           7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};
      logic [47:0] x;
      logic [31:0] s = '0;
      logic [5:0]  six;
      logic [63:0] pw;
      x = 48'(select_bits({32'h0, rh}, 32, 48, ex)) ^ sk;
      for (int i = 0; i < 8; i++) begin
         six = x[47-6*i -: 6];
         // row from the outer bits, column from the inner four
         s = {s[27:0], 4'(sb[i][{six[5], six[0], six[4:1]}])};
      end
      pw = select_bits({32'h0, s}, 32, 32, pp);
      return pw[31:0];
   endfunction

   function automatic logic [63:0] des_transform(input logic decrypt, input logic [63:0] blk);
      int ip[] = '{58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,62,54,46,38,30,22,14,6,
                   64,56,48,40,32,24,16,8,57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
                   61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
      int fp[] = '{40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,38,6,46,14,54,22,62,30,
                   37,5,45,13,53,21,61,29,36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
                   34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
      logic [63:0] b;
      logic [31:0] l;
      logic [31:0] r;
      logic [31:0] t;
      b = select_bits(blk, 64, 64, ip);
      l = b[63:32];
      r = b[31:0];
      for (int i = 0; i < 16; i++) begin
         t = r;
         r = l ^ round_fn(r, round_keys[decrypt ? 15 - i : i]);
         l = t;
      end
      return select_bits({r, l}, 64, 64, fp);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic write_key(input logic [63:0] key);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = key;
      @(negedge clock);
      csr_we    = 1'b0;
      schedule_keys(key);
   endtask

   task automatic drain();
      wait (pending_blocks.size() == 0 && expected_text.size() == 0 && !req_tvalid);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold the offered transaction
      end else if (send_wait > 0) begin
         send_wait  <= send_wait - 1;
         req_tvalid <= 1'b0;
      end else if (pending_blocks.size() > 0) begin
         req_tvalid <= 1'b1;
         req_tuser  <= pending_blocks[0].decrypt;
         req_tdata  <= pending_blocks[0].block;
         expected_text.push_back(des_transform(pending_blocks[0].decrypt,
                                               pending_blocks[0].block));
         void'(pending_blocks.pop_front());
         send_wait  <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold > 0) begin
         long_hold  <= long_hold - 1;
         rsp_tready <= 1'b0;
      end else if (recv_wait > 0) begin
         recv_wait  <= recv_wait - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_tvalid && rsp_tready)
            recv_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_text.size() == 0) begin
               $error("unexpected transaction text_out=%h", rsp_tdata);
               errors++;
            end else begin
               if (rsp_tdata !== expected_text[0]) begin
                  $error("text_out expected %h actual %h", expected_text[0], rsp_tdata);
                  errors++;
               end
               void'(expected_text.pop_front());
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || csr_we || (expected_text.size() == 0 && !req_tvalid))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT)
            timed_out = 1;
      end
   end

   initial begin
      wait (timed_out);
      $display("tb_top failed");
      $finish;
   end

   initial begin
      logic [63:0] keys[5];
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      rsp_tready = 1'b0;
      schedule_keys(64'h0);
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // key never written: reset value in use
      pending_blocks.push_back('{1'b0, 64'h0});
      pending_blocks.push_back('{1'b1, 64'hFFFF_FFFF_FFFF_FFFF});
      drain();

      write_key(64'h1334_5779_9BBC_DFF1);
      pending_blocks.push_back('{1'b0, 64'h0123_4567_89AB_CDEF});
      pending_blocks.push_back('{1'b1, 64'h85E8_1354_0F0A_B405});
      pending_blocks.push_back('{1'b0, 64'h0});
      pending_blocks.push_back('{1'b0, 64'hFFFF_FFFF_FFFF_FFFF});
      pending_blocks.push_back('{1'b1, 64'h0});
      pending_blocks.push_back('{1'b1, 64'hFFFF_FFFF_FFFF_FFFF});
      for (int i = 0; i < 64; i += 8)
         pending_blocks.push_back('{i[3], 64'h1 << i});
      drain();

      keys = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0101_0101_0101_0101,
               rand64(), rand64()};
      for (int ph = 0; ph < 5; ph++) begin
         write_key(keys[ph]);
         if (ph == 2) long_hold = 200;  // pipe fills and stalls the input
         for (int i = 0; i < RANDOM_ITEMS / 5; i++)
            pending_blocks.push_back('{1'($urandom), rand64()});
         drain();
      end

      if (errors == 0 && expected_text.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/des_pkg.sv
design/des_round.sv
design/des_block_cipher_top.sv
tb/sv/tb_top.sv
